// ----- rtl/core/mbt_pkg.sv -----
// Shared types and codes for the markdown block tokenizer.
package mbt_pkg;

    // Lexer modes
    localparam logic [3:0] M_BLOCK = 4'd0;
    localparam logic [3:0] M_POST  = 4'd1;
    localparam logic [3:0] M_PLINE = 4'd2;
    localparam logic [3:0] M_PLS   = 4'd3;
    localparam logic [3:0] M_HHASH = 4'd4;
    localparam logic [3:0] M_HWS   = 4'd5;
    localparam logic [3:0] M_HLINE = 4'd6;
    localparam logic [3:0] M_QMARK = 4'd7;
    localparam logic [3:0] M_QWS   = 4'd8;
    localparam logic [3:0] M_QLINE = 4'd9;
    localparam logic [3:0] M_QLS   = 4'd10;
    localparam logic [3:0] M_OLINE = 4'd11;
    localparam logic [3:0] M_OLS   = 4'd12;
    localparam logic [3:0] M_ULINE = 4'd13;
    localparam logic [3:0] M_ULS   = 4'd14;

    // Token kinds (1..6 are heading levels)
    localparam logic [3:0] K_PARA  = 4'd0;
    localparam logic [3:0] K_HEAD1 = 4'd1;
    localparam logic [3:0] K_QUOTE = 4'd7;
    localparam logic [3:0] K_OLIST = 4'd8;
    localparam logic [3:0] K_ULIST = 4'd9;
    localparam logic [3:0] K_END   = 4'd10;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] HEAD_MAX = 3'd6;
    localparam int         MAX_RES  = 3;

    // Lexer control state
    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] kind;
        logic [2:0] mcount;
        logic       stopped;
    } lex_ctrl_t;

    // One result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic        last;
    } result_t;

endpackage

// ----- rtl/core/mbt_lexer.sv -----
// Next-state and result logic for one text byte.
module mbt_lexer #(
    parameter int POS_BITS = 16
) (
    input  mbt_pkg::lex_ctrl_t  ctrl_cur,
    input  logic [POS_BITS-1:0] cs_cur,
    input  logic [POS_BITS-1:0] ce_cur,
    input  logic [POS_BITS-1:0] pos_cur,
    input  logic [7:0]          text_byte,
    input  logic                last_byte,
    output mbt_pkg::lex_ctrl_t  ctrl_next,
    output logic [POS_BITS-1:0] cs_next,
    output logic [POS_BITS-1:0] ce_next,
    output logic [POS_BITS-1:0] pos_next,
    output mbt_pkg::result_t    res [mbt_pkg::MAX_RES],
    output logic [1:0]          res_count
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    always_comb
    begin
        logic [3:0]          md;
        logic [3:0]          kd;
        logic [2:0]          mc;
        logic                st;
        logic [POS_BITS-1:0] cs;
        logic [POS_BITS-1:0] ce;
        logic [POS_BITS-1:0] p;
        logic [POS_BITS-1:0] pn;
        logic [1:0]          n;
        logic                do_after;
        logic                do_start;
        logic                go_hws;
        logic                go_hline;
        logic                go_qws;
        logic                go_qline;
        logic                is_dig;
        logic [7:0]          c;
        logic                pass_eot;

        md = ctrl_cur.mode;
        kd = ctrl_cur.kind;
        mc = ctrl_cur.mcount;
        st = ctrl_cur.stopped;
        cs = cs_cur;
        ce = ce_cur;
        p  = pos_cur;
        pn = pos_cur;
        n  = 2'd0;
        c  = text_byte;
        do_after = 1'b0;
        do_start = 1'b0;
        go_hws   = 1'b0;
        go_hline = 1'b0;
        go_qws   = 1'b0;
        go_qline = 1'b0;
        pass_eot = 1'b0;
        is_dig   = (c >= mbt_pkg::CH_ZERO) && (c <= mbt_pkg::CH_NINE);
        for (int i = 0; i < mbt_pkg::MAX_RES; i++)
        begin
            res[i] = '0;
        end

        if (!st)
        begin
            // Two passes: the byte itself, then the end flush for a last byte
            for (int pass = 0; pass < 2; pass++)
            begin
                pass_eot = (pass == 0) ? (c == mbt_pkg::CH_NUL) : (last_byte && !st);
                if (pass == 1)
                begin
                    pn = (pos_cur < POS_MAX) ? pos_cur + POS_BITS'(1) : pos_cur;
                    p  = pn;
                end
                if (pass_eot)
                begin
                    // Flush the pending span
                    case (md)
                        mbt_pkg::M_PLINE, mbt_pkg::M_HLINE, mbt_pkg::M_QLINE,
                        mbt_pkg::M_OLINE, mbt_pkg::M_ULINE:
                        begin
                            res[n] = '{kd, 16'(cs), 16'(p), 1'b0};
                            n = n + 2'd1;
                        end
                        mbt_pkg::M_HHASH, mbt_pkg::M_HWS, mbt_pkg::M_QMARK,
                        mbt_pkg::M_QWS:
                        begin
                            res[n] = '{kd, 16'(p), 16'(p), 1'b0};
                            n = n + 2'd1;
                        end
                        mbt_pkg::M_PLS, mbt_pkg::M_QLS, mbt_pkg::M_OLS,
                        mbt_pkg::M_ULS:
                        begin
                            res[n] = '{kd, 16'(cs), 16'(ce), 1'b0};
                            n = n + 2'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                    res[n] = '{mbt_pkg::K_END, 16'd0, 16'd0, 1'b0};
                    n = n + 2'd1;
                    st = 1'b1;
                end
                else if (pass == 0)
                begin
                    // Feed one byte
                    case (md)
                        mbt_pkg::M_BLOCK: do_start = 1'b1;
                        mbt_pkg::M_POST:  do_after = 1'b1;
                        mbt_pkg::M_PLINE:
                        begin
                            if (c == mbt_pkg::CH_NL)
                            begin
                                ce = p;
                                md = mbt_pkg::M_PLS;
                            end
                        end
                        mbt_pkg::M_PLS:
                        begin
                            if (c == mbt_pkg::CH_NL)
                            begin
                                res[n] = '{kd, 16'(cs), 16'(ce), 1'b0};
                                n = n + 2'd1;
                                do_after = 1'b1;
                            end
                            else
                            begin
                                md = mbt_pkg::M_PLINE;
                            end
                        end
                        mbt_pkg::M_HHASH:
                        begin
                            if (c == mbt_pkg::CH_HASH)
                            begin
                                if (mc < mbt_pkg::HEAD_MAX)
                                begin
                                    mc = mc + 3'd1;
                                end
                                kd = {1'b0, mc};
                            end
                            else
                            begin
                                go_hws = 1'b1;
                            end
                        end
                        mbt_pkg::M_HWS:   go_hws = 1'b1;
                        mbt_pkg::M_HLINE: go_hline = 1'b1;
                        mbt_pkg::M_QMARK:
                        begin
                            if (c != mbt_pkg::CH_GT)
                            begin
                                go_qws = 1'b1;
                            end
                        end
                        mbt_pkg::M_QWS:   go_qws = 1'b1;
                        mbt_pkg::M_QLINE: go_qline = 1'b1;
                        mbt_pkg::M_QLS:
                        begin
                            if (c == mbt_pkg::CH_GT)
                            begin
                                mc = 3'd1;
                            end
                            else if (mc != 3'd0 && c != mbt_pkg::CH_NL)
                            begin
                                md = mbt_pkg::M_QLINE;
                            end
                            else
                            begin
                                res[n] = '{kd, 16'(cs), 16'(ce), 1'b0};
                                n = n + 2'd1;
                                do_after = 1'b1;
                            end
                        end
                        mbt_pkg::M_OLINE, mbt_pkg::M_ULINE:
                        begin
                            if (c == mbt_pkg::CH_NL)
                            begin
                                ce = p;
                                md = (md == mbt_pkg::M_OLINE) ? mbt_pkg::M_OLS
                                                              : mbt_pkg::M_ULS;
                            end
                        end
                        mbt_pkg::M_OLS, mbt_pkg::M_ULS:
                        begin
                            if (c != mbt_pkg::CH_SPACE)
                            begin
                                if ((md == mbt_pkg::M_OLS && is_dig) ||
                                    (md == mbt_pkg::M_ULS && c == mbt_pkg::CH_DASH))
                                begin
                                    md = (md == mbt_pkg::M_OLS) ? mbt_pkg::M_OLINE
                                                                : mbt_pkg::M_ULINE;
                                end
                                else
                                begin
                                    res[n] = '{kd, 16'(cs), 16'(ce), 1'b0};
                                    n = n + 2'd1;
                                    do_after = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            md = mbt_pkg::M_BLOCK;
                            do_start = 1'b1;
                        end
                    endcase

                    // Heading: spaces after the marker, then the text line
                    if (go_hws)
                    begin
                        md = mbt_pkg::M_HWS;
                        if (c != mbt_pkg::CH_SPACE)
                        begin
                            cs = p;
                            md = mbt_pkg::M_HLINE;
                            go_hline = 1'b1;
                        end
                    end
                    if (go_hline && c == mbt_pkg::CH_NL)
                    begin
                        ce = p;
                        res[n] = '{kd, 16'(cs), 16'(ce), 1'b0};
                        n = n + 2'd1;
                        md = mbt_pkg::M_POST;
                    end

                    // Quote: spaces after the marker, then the text line
                    if (go_qws)
                    begin
                        md = mbt_pkg::M_QWS;
                        if (c != mbt_pkg::CH_SPACE)
                        begin
                            cs = p;
                            md = mbt_pkg::M_QLINE;
                            go_qline = 1'b1;
                        end
                    end
                    if (go_qline && c == mbt_pkg::CH_NL)
                    begin
                        ce = p;
                        mc = 3'd0;
                        md = mbt_pkg::M_QLS;
                    end

                    // Skip after a token
                    if (do_after)
                    begin
                        if (c == mbt_pkg::CH_SPACE)
                        begin
                            md = mbt_pkg::M_POST;
                        end
                        else if (c == mbt_pkg::CH_NL)
                        begin
                            md = mbt_pkg::M_BLOCK;
                        end
                        else
                        begin
                            do_start = 1'b1;
                        end
                    end

                    // First byte of a block picks its kind
                    if (do_start)
                    begin
                        cs = p;
                        if (is_dig)
                        begin
                            kd = mbt_pkg::K_OLIST;
                            md = mbt_pkg::M_OLINE;
                        end
                        else if (c == mbt_pkg::CH_DASH)
                        begin
                            kd = mbt_pkg::K_ULIST;
                            md = mbt_pkg::M_ULINE;
                        end
                        else if (c == mbt_pkg::CH_HASH)
                        begin
                            mc = 3'd1;
                            kd = mbt_pkg::K_HEAD1;
                            md = mbt_pkg::M_HHASH;
                        end
                        else if (c == mbt_pkg::CH_GT)
                        begin
                            kd = mbt_pkg::K_QUOTE;
                            md = mbt_pkg::M_QMARK;
                        end
                        else
                        begin
                            kd = mbt_pkg::K_PARA;
                            if (c == mbt_pkg::CH_NL)
                            begin
                                ce = p;
                                md = mbt_pkg::M_PLS;
                            end
                            else
                            begin
                                md = mbt_pkg::M_PLINE;
                            end
                        end
                    end
                end
            end

            // Mark the final result of this byte
            if (n != 2'd0)
            begin
                res[n - 2'd1].last = 1'b1;
            end
        end

        ctrl_next = '{md, kd, mc, st};
        cs_next   = cs;
        ce_next   = ce;
        pos_next  = pn;
        res_count = n;
    end

endmodule

// ----- rtl/core/mbt_result_fifo.sv -----
// Four-entry result queue taking up to three items per cycle.
module mbt_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  mbt_pkg::result_t push_data [mbt_pkg::MAX_RES],
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output mbt_pkg::result_t out_data
);

    mbt_pkg::result_t mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Space for a full burst of three after this cycle's pop
    assign room = ((count_reg - {2'b00, pop}) <= 3'd1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_count} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mbt_pkg::MAX_RES; i++)
        begin
            if (2'(i) < push_count)
            begin
                mem[wr_ptr_reg + 2'(i)] <= push_data[i];
            end
        end
    end

endmodule

// ----- rtl/core/markdown_block_tokenizer.sv -----
// Top level of the markdown block tokenizer.
//
//  channel     | handshake                     | payload
//  ------------+-------------------------------+------------------------------------------
//  input item  | in_valid / in_ready           | text_byte[7:0], last_byte
//  result item | out_valid / out_ready         | token_kind[3:0], span_start, span_end,
//              |                               | last_of_step
//  config      | base_offset_we (no wait)      | base_offset[15:0]
//
// One byte per cycle while the queue has room: a byte is held in the input register,
// is lexed combinationally from it and its 0 to 3 result items land in a four-entry
// queue, on the output from the next cycle. A byte is lexed only while the queue, after
// this cycle's pop, holds at most one item, so with the output stalled the input side
// stops once two result items wait. Results leave one per cycle while out_ready is high.
// Reset clears the lexer state, the position and the queue; it takes no sweep.
module markdown_block_tokenizer #(
    parameter int POS_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        base_offset_we,
    input  logic [15:0] base_offset,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] span_start,
    output logic [15:0] span_end,
    output logic        last_of_step
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Input register
    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Lexer state
    mbt_pkg::lex_ctrl_t  ctrl_reg;
    mbt_pkg::lex_ctrl_t  ctrl_next;
    logic [POS_BITS-1:0] cs_reg;
    logic [POS_BITS-1:0] cs_next;
    logic [POS_BITS-1:0] ce_reg;
    logic [POS_BITS-1:0] ce_next;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic                begun_reg;
    logic [POS_BITS-1:0] base_sat;

    mbt_pkg::result_t res [mbt_pkg::MAX_RES];
    logic [1:0]       res_count;
    logic [1:0]       push_count;
    logic             room;
    logic             fire;
    mbt_pkg::result_t out_data;

    assign fire     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || fire;

    // Base offset clamped to the position range
    assign base_sat = (32'(base_offset) > 32'(POS_MAX)) ? POS_MAX
                                                        : POS_BITS'(base_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= text_byte;
            last_reg <= last_byte;
        end
    end

    // State update on each lexed byte; base load only before the first byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '{mbt_pkg::M_BLOCK, mbt_pkg::K_PARA, 3'd0, 1'b0};
            cs_reg    <= '0;
            ce_reg    <= '0;
            pos_reg   <= '0;
            begun_reg <= 1'b0;
        end
        else if (fire)
        begin
            ctrl_reg  <= ctrl_next;
            cs_reg    <= cs_next;
            ce_reg    <= ce_next;
            pos_reg   <= pos_next;
            begun_reg <= 1'b1;
        end
        else if (base_offset_we && !begun_reg)
        begin
            pos_reg <= base_sat;
        end
    end

    mbt_lexer #(
        .POS_BITS (POS_BITS)
    ) u_lexer (
        .ctrl_cur  (ctrl_reg),
        .cs_cur    (cs_reg),
        .ce_cur    (ce_reg),
        .pos_cur   (pos_reg),
        .text_byte (byte_reg),
        .last_byte (last_reg),
        .ctrl_next (ctrl_next),
        .cs_next   (cs_next),
        .ce_next   (ce_next),
        .pos_next  (pos_next),
        .res       (res),
        .res_count (res_count)
    );

    assign push_count = fire ? res_count : 2'd0;

    mbt_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (res),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign token_kind   = out_data.kind;
    assign span_start   = out_data.span_start;
    assign span_end     = out_data.span_end;
    assign last_of_step = out_data.last;

endmodule
